// ----- rtl/core/si2dec_pkg.sv -----
package si2dec_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } back_state_t;

endpackage

// ----- rtl/core/si2dec_front.sv -----
module si2dec_front
    import si2dec_pkg::*;
(
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      q_ready,
    output logic                      q_push,
    output entry_t                    q_entry
);

    logic [VALUE_W-1:0] raw;

    assign raw           = VALUE_W'(s_value);
    assign s_ready       = q_ready;
    assign q_push        = s_valid && q_ready;
    assign q_entry.neg   = raw[VALUE_W-1];
    // two's complement magnitude, most negative value maps onto its unsigned image
    assign q_entry.mag   = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

endmodule

// ----- rtl/core/si2dec_queue.sv -----
module si2dec_queue
    import si2dec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   not_full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != CNT_W'(DEPTH))
        else $error("push into full queue");

endmodule

// ----- rtl/core/si2dec_back.sv -----
module si2dec_back
    import si2dec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  entry_t            q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_character,
    output logic              m_last
);

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_W - 1);

    back_state_t          state_reg, state_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0] ndig_reg, ndig_next;
    logic                 neg_reg, neg_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    m_char_reg, m_char_next;
    logic                 m_last_reg, m_last_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_digit;
    logic                 out_free;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !m_valid_reg || m_ready;

    // add-3 correction on every digit ahead of the shift
    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        bcd_next     = bcd_reg;
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        neg_next     = neg_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop        = 1'b1;
                    bin_next     = q_head.mag;
                    neg_next     = q_head.neg;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_LAST) begin
                    ndig_next  = DIG_CNT_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && ndig_reg != DIG_CNT_W'(1)) begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - DIG_CNT_W'(1);
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ASCII_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ASCII_ZERO + {2'b00, top_digit};
                    m_last_next  = (ndig_reg == DIG_CNT_W'(1));
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next    = ndig_reg - DIG_CNT_W'(1);
                    if (ndig_reg == DIG_CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg     <= bcd_next;
        bin_reg     <= bin_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
        neg_reg     <= neg_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

    a_conv_to_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && bit_cnt_reg == BIT_LAST) |=> state_reg == ST_SKIP)
        else $error("conversion did not end after last bit");

    a_sign_only_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SIGN |-> neg_reg)
        else $error("minus sign for non-negative value");

    a_digits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SKIP || state_reg == ST_DIGIT) |-> ndig_reg != '0)
        else $error("digit count ran out");

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// conversion: 32 shift-add-3 steps, then suppression of leading zeros, then one
// character per cycle while m_ready is high
// requests: the back end converts one at a time, through the bit-serial bcd loop and
// the character emission; the front takes new requests into the queue meanwhile
// reset: synchronous active-low aresetn clears queue, state machine and output valid
module signed_int_to_decimal_ascii
    import si2dec_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CHAR_W-1:0]         m_character,
    output logic                      m_last
);

    logic   q_push, q_pop, q_not_full, q_not_empty;
    entry_t q_entry, q_head;

    si2dec_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .q_ready (q_not_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    si2dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    si2dec_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule
